// ----- rtl/llw_pkg.sv -----
// ----------------------------------------------------------------------------
// llw_pkg
// shared types and constants of the link liveness watchdog
// ----------------------------------------------------------------------------
package llw_pkg;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_REPLY   = 2'd1,
      OP_START   = 2'd2,
      OP_RESTART = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_ENABLE         = 3'd0,
      REG_START_DELAY    = 3'd1,
      REG_CHECK_INTERVAL = 3'd2,
      REG_PROBES         = 3'd3,
      REG_FAILURE_LIMIT  = 3'd4
   } reg_index_type;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   localparam logic [15:0] PROBE_IDENT     = 16'hAFAF;
   localparam logic [7:0]  ECHO_REPLY_KIND = 8'd0;
   localparam logic [15:0] ESCALATION_WAIT = 16'd2;

   typedef struct packed {
      logic        enable;
      logic [15:0] start_delay;
      logic [15:0] check_interval;
      logic [7:0]  probes_per_check;
      logic [7:0]  failure_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic        transmit_ready;
      logic [15:0] reply_ident;
      logic [7:0]  reply_kind;
      logic [15:0] reply_sequence;
   } item_type;

   typedef struct packed {
      logic        send_probe;
      logic [15:0] probe_sequence;
      logic        check_done;
      logic        check_failed;
      logic [1:0]  escalation;
      logic        reply_matched;
   } result_type;

endpackage

// ----- rtl/link_liveness_watchdog.sv -----
// ----------------------------------------------------------------------------
// link_liveness_watchdog
// echo-probe supervisor for one network peer
// ----------------------------------------------------------------------------
// usage
//   req_* carries one event per transfer: tick, echo reply, start or restart.
//   rsp_* returns exactly one result per event, in order.
//   csr_* writes the five configuration registers; csr_ready is always high.
//   registers may only be written while no event is in flight.
// pipeline and throughput
//   an accepted event waits in the input register, is processed
//   in one pass through the engine and appears on rsp_* the next cycle.
//   one event per cycle is sustained while rsp_stall holds no waiting
//   result, as the engine updates its state in one pass.
// stalls
//   while rsp_stall holds a waiting result, the input register keeps its
//   event and req_stall rises once that register is full.
// reset
//   synchronous, active high: timers, counters, sequence cleared,
//   registers back to their defaults, both channels empty.
// ----------------------------------------------------------------------------
module link_liveness_watchdog (
   input  logic                                 clock,
   input  logic                                 reset,
   // event channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_operation,
   input  logic                                 req_transmit_ready,
   input  logic [15:0]                          req_reply_ident,
   input  logic [7:0]                           req_reply_kind,
   input  logic [15:0]                          req_reply_sequence,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_send_probe,
   output logic [15:0]                          rsp_probe_sequence,
   output logic                                 rsp_check_done,
   output logic                                 rsp_check_failed,
   output logic [1:0]                           rsp_escalation,
   output logic                                 rsp_reply_matched,
   // configuration channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [llw_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [llw_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import llw_pkg::*;

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       in_valid_ff, in_valid_in;
   result_type result;
   result_type result_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_take;
   logic       advance;

   // register bank, always ready
   assign csr_ready = 1'b1;

   llw_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // processing happens when the input register holds an event and the
   // result register is empty or being drained this cycle
   assign advance   = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      item_in.operation      = req_operation;
      item_in.transmit_ready = req_transmit_ready;
      item_in.reply_ident    = req_reply_ident;
      item_in.reply_kind     = req_reply_kind;
      item_in.reply_sequence = req_reply_sequence;
      in_valid_in            = req_take | (in_valid_ff & ~advance);
      rsp_valid_in           = advance | (rsp_valid_ff & rsp_stall);
   end

   llw_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_send_probe     = result_ff.send_probe;
   assign rsp_probe_sequence = result_ff.probe_sequence;
   assign rsp_check_done     = result_ff.check_done;
   assign rsp_check_failed   = result_ff.check_failed;
   assign rsp_escalation     = result_ff.escalation;
   assign rsp_reply_matched  = result_ff.reply_matched;

   // a failed check is always an ended burst
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_check_failed |-> rsp_check_done)
      else $error("check_failed without check_done");

   // escalation only follows a failed check
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_escalation != 2'd0 |-> rsp_check_failed)
      else $error("escalation without a failed check");

   // a probe and a matched reply come from different event kinds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_send_probe && rsp_reply_matched))
      else $error("probe and reply match in one result");

   // a processed event always shows up as a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed event lost before the result register");

endmodule

// ----- rtl/llw_csr.sv -----
// ----------------------------------------------------------------------------
// llw_csr
// configuration register bank
// ----------------------------------------------------------------------------
module llw_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  wr_en,
   input  logic [llw_pkg::CSR_INDEX_WIDTH-1:0]   wr_index,
   input  logic [llw_pkg::CSR_DATA_WIDTH-1:0]    wr_data,
   output llw_pkg::cfg_type                      cfg
);
   import llw_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            REG_ENABLE:         cfg_in.enable           = wr_data[0];
            REG_START_DELAY:    cfg_in.start_delay      = wr_data;
            REG_CHECK_INTERVAL: cfg_in.check_interval   = wr_data;
            REG_PROBES:         cfg_in.probes_per_check = wr_data[7:0];
            REG_FAILURE_LIMIT:  cfg_in.failure_limit    = wr_data[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable           <= 1'b1;
         cfg_ff.start_delay      <= 16'd60;
         cfg_ff.check_interval   <= 16'd60;
         cfg_ff.probes_per_check <= 8'd3;
         cfg_ff.failure_limit    <= 8'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/llw_engine.sv -----
// ----------------------------------------------------------------------------
// llw_engine
// supervision state and the single-pass update for one item
// ----------------------------------------------------------------------------
module llw_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  llw_pkg::item_type   item,
   input  llw_pkg::cfg_type    cfg,
   output llw_pkg::result_type result
);
   import llw_pkg::*;

   logic [15:0] start_timer_ff,    start_timer_in;
   logic [15:0] interval_timer_ff, interval_timer_in;
   logic [7:0]  burst_left_ff,     burst_left_in;
   logic [7:0]  outstanding_ff,    outstanding_in;
   logic [7:0]  failures_ff,       failures_in;
   logic [15:0] sequence_ff,       sequence_in;

   always_comb begin
      logic [7:0]  out_next;
      logic [7:0]  fail_next;
      logic [7:0]  burst_dec;
      logic [15:0] timer_dec;
      logic [8:0]  level;

      start_timer_in    = start_timer_ff;
      interval_timer_in = interval_timer_ff;
      burst_left_in     = burst_left_ff;
      outstanding_in    = outstanding_ff;
      failures_in       = failures_ff;
      sequence_in       = sequence_ff;
      result            = '0;
      out_next          = outstanding_ff;
      fail_next         = failures_ff;
      burst_dec         = burst_left_ff - 8'd1;
      timer_dec         = 16'd0;
      level             = 9'd0;

      unique case (op_type'(item.operation))
         OP_TICK: begin
            if (cfg.enable) begin
               if (start_timer_ff == 16'd0 && interval_timer_ff == 16'd0) begin
                  if (item.transmit_ready) begin
                     result.send_probe = 1'b1;
                     sequence_in       = sequence_ff + 16'd1;
                     if (outstanding_ff != 8'hFF) begin
                        out_next = outstanding_ff + 8'd1;
                     end
                  end
                  outstanding_in = out_next;
                  burst_left_in  = burst_dec;
                  if (burst_dec == 8'd0) begin
                     result.check_done = 1'b1;
                     interval_timer_in = cfg.check_interval;
                     if (out_next < cfg.probes_per_check) begin
                        failures_in = 8'd0;
                     end else begin
                        result.check_failed = 1'b1;
                        if (failures_ff != 8'hFF) begin
                           fail_next = failures_ff + 8'd1;
                        end
                        failures_in = fail_next;
                        if (fail_next >= cfg.failure_limit) begin
                           // level counts from one at the limit
                           level = {1'b0, fail_next} + 9'd1 - {1'b0, cfg.failure_limit};
                           result.escalation = (level <= 9'd3) ? level[1:0] : 2'd0;
                           interval_timer_in = ESCALATION_WAIT;
                        end
                     end
                     outstanding_in = 8'd0;
                  end
               end else if (start_timer_ff != 16'd0) begin
                  timer_dec      = start_timer_ff - 16'd1;
                  start_timer_in = timer_dec;
                  if (timer_dec == 16'd0) begin
                     burst_left_in  = cfg.probes_per_check;
                     outstanding_in = 8'd0;
                  end
               end else begin
                  timer_dec         = interval_timer_ff - 16'd1;
                  interval_timer_in = timer_dec;
                  if (timer_dec == 16'd0) begin
                     burst_left_in  = cfg.probes_per_check;
                     outstanding_in = 8'd0;
                  end
               end
            end
         end
         OP_REPLY: begin
            if (item.reply_ident == PROBE_IDENT && item.reply_kind == ECHO_REPLY_KIND &&
                item.reply_sequence == sequence_ff) begin
               result.reply_matched = 1'b1;
               if (outstanding_ff != 8'd0) begin
                  outstanding_in = outstanding_ff - 8'd1;
               end
            end
         end
         OP_START: begin
            start_timer_in    = cfg.start_delay;
            failures_in       = 8'd0;
            interval_timer_in = 16'd0;
            burst_left_in     = 8'd0;
            outstanding_in    = 8'd0;
         end
         OP_RESTART: begin
            burst_left_in     = cfg.probes_per_check;
            start_timer_in    = 16'd0;
            interval_timer_in = 16'd0;
         end
         default: begin
            result = '0;
         end
      endcase

      result.probe_sequence = sequence_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_timer_ff    <= '0;
         interval_timer_ff <= '0;
         burst_left_ff     <= '0;
         outstanding_ff    <= '0;
         failures_ff       <= '0;
         sequence_ff       <= '0;
      end else if (fire) begin
         start_timer_ff    <= start_timer_in;
         interval_timer_ff <= interval_timer_in;
         burst_left_ff     <= burst_left_in;
         outstanding_ff    <= outstanding_in;
         failures_ff       <= failures_in;
         sequence_ff       <= sequence_in;
      end
   end

endmodule

// ----- bench/link_liveness_watchdog_tb.sv -----
// ----------------------------------------------------------------------------
// link_liveness_watchdog_tb
// self-checking bench: events in, one predicted report per event checked out
// ----------------------------------------------------------------------------
// a behavioural copy of the supervisor runs alongside the block and queues
// the report each accepted event should produce; every report transfer is
// compared field by field with the oldest one queued. directed tests cover
// power-on state, the escalation ladder and disabled supervision, then
// random phases mix well-formed probe/reply traffic with noise under
// several register settings, including both extremes
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module link_liveness_watchdog_tb;
   import llw_pkg::*;

   // generous bound on cycles without any transfer; the slowest legal
   // stretch is a short idle burst or the settle time between phases
   localparam int unsigned STALL_LIMIT = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid          = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation      = '0;
   logic        req_transmit_ready = 1'b0;
   logic [15:0] req_reply_ident    = '0;
   logic [7:0]  req_reply_kind     = '0;
   logic [15:0] req_reply_sequence = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_send_probe;
   logic [15:0] rsp_probe_sequence;
   logic        rsp_check_done;
   logic        rsp_check_failed;
   logic [1:0]  rsp_escalation;
   logic        rsp_reply_matched;

   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data  = '0;

   // shadow of the supervisor: registers and counters
   cfg_type     watch_cfg;
   logic [15:0] start_count;
   logic [15:0] interval_count;
   logic [7:0]  slots_left;
   logic [7:0]  probes_open;
   logic [7:0]  failed_checks;
   logic [15:0] probe_seq;

   // reports still owed by the block, oldest first
   result_type  awaited_reports[$];

   // no idling on either side while set
   bit          steady = 1'b0;

   int unsigned error_count      = 0;
   int unsigned events_sent      = 0;
   int unsigned reports_checked  = 0;
   int unsigned probes_seen      = 0;
   int unsigned bursts_ended     = 0;
   int unsigned escalations_seen = 0;
   int unsigned idle_cycles      = 0;

   link_liveness_watchdog dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_transmit_ready (req_transmit_ready),
      .req_reply_ident    (req_reply_ident),
      .req_reply_kind     (req_reply_kind),
      .req_reply_sequence (req_reply_sequence),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_send_probe     (rsp_send_probe),
      .rsp_probe_sequence (rsp_probe_sequence),
      .rsp_check_done     (rsp_check_done),
      .rsp_check_failed   (rsp_check_failed),
      .rsp_escalation     (rsp_escalation),
      .rsp_reply_matched  (rsp_reply_matched),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // prediction: applies one event to the shadow state, returns its report
   // ------------------------------------------------------------------------
   function automatic result_type supervise(input item_type ev);
      result_type rep;
      logic [8:0] level;
      rep = '0;
      case (ev.operation)
         OP_TICK: begin
            // disabled supervision freezes everything on a tick
            if (watch_cfg.enable) begin
               if (start_count == 16'd0 && interval_count == 16'd0) begin
                  // burst tick: one slot used, probe only if tx can take it
                  if (ev.transmit_ready) begin
                     rep.send_probe = 1'b1;
                     probe_seq      = probe_seq + 16'd1;
                     if (probes_open != 8'hFF) probes_open = probes_open + 8'd1;
                  end
                  // an empty slot count wraps round to 255, making a 256-slot burst
                  slots_left = slots_left - 8'd1;
                  if (slots_left == 8'd0) begin
                     rep.check_done = 1'b1;
                     interval_count = watch_cfg.check_interval;
                     if (probes_open < watch_cfg.probes_per_check) begin
                        // fewer probes open than the probes per check
                        failed_checks = 8'd0;
                     end else begin
                        rep.check_failed = 1'b1;
                        if (failed_checks != 8'hFF) failed_checks = failed_checks + 8'd1;
                        if (failed_checks >= watch_cfg.failure_limit) begin
                           level = 9'd1 + {1'b0, failed_checks}
                                   - {1'b0, watch_cfg.failure_limit};
                           // levels beyond reboot are reported as none
                           rep.escalation = (level <= 9'd3) ? level[1:0] : 2'd0;
                           interval_count = ESCALATION_WAIT;
                        end
                     end
                     probes_open = 8'd0;
                  end
               end else if (start_count != 16'd0) begin
                  start_count = start_count - 16'd1;
                  if (start_count == 16'd0) begin
                     slots_left  = watch_cfg.probes_per_check;
                     probes_open = 8'd0;
                  end
               end else begin
                  interval_count = interval_count - 16'd1;
                  if (interval_count == 16'd0) begin
                     slots_left  = watch_cfg.probes_per_check;
                     probes_open = 8'd0;
                  end
               end
            end
         end
         OP_REPLY: begin
            // replies count even while supervision is off
            if (ev.reply_ident == PROBE_IDENT && ev.reply_kind == ECHO_REPLY_KIND
                && ev.reply_sequence == probe_seq) begin
               rep.reply_matched = 1'b1;
               if (probes_open != 8'd0) probes_open = probes_open - 8'd1;
            end
         end
         OP_START: begin
            start_count    = watch_cfg.start_delay;
            failed_checks  = 8'd0;
            interval_count = 16'd0;
            slots_left     = 8'd0;
            probes_open    = 8'd0;
         end
         default: begin
            // restart: next tick is a burst tick
            slots_left     = watch_cfg.probes_per_check;
            start_count    = 16'd0;
            interval_count = 16'd0;
         end
      endcase
      rep.probe_sequence = probe_seq;
      return rep;
   endfunction

   // ------------------------------------------------------------------------
   // event channel: one transfer, with a random gap in front of it
   // ------------------------------------------------------------------------
   task automatic send_event(input item_type ev);
      while (!steady && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_operation      <= ev.operation;
      req_transmit_ready <= ev.transmit_ready;
      req_reply_ident    <= ev.reply_ident;
      req_reply_kind     <= ev.reply_kind;
      req_reply_sequence <= ev.reply_sequence;
      do @(posedge clock); while (req_stall);
      // transfer taken at this edge: the shadow moves on in step
      awaited_reports.push_back(supervise(ev));
      events_sent++;
   endtask

   task automatic send_op(input op_type op, input logic ready, input logic [15:0] ident,
                          input logic [7:0] kind, input logic [15:0] seq);
      item_type ev;
      ev.operation      = op;
      ev.transmit_ready = ready;
      ev.reply_ident    = ident;
      ev.reply_kind     = kind;
      ev.reply_sequence = seq;
      send_event(ev);
   endtask

   // quiesce: no event in flight and every owed report delivered
   task automatic settle();
      req_valid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // register writes, only issued once the block has settled
   // ------------------------------------------------------------------------
   task automatic write_reg(input reg_index_type idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_ENABLE:         watch_cfg.enable           = value[0];
         REG_START_DELAY:    watch_cfg.start_delay      = value;
         REG_CHECK_INTERVAL: watch_cfg.check_interval   = value;
         REG_PROBES:         watch_cfg.probes_per_check = value[7:0];
         REG_FAILURE_LIMIT:  watch_cfg.failure_limit    = value[7:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic en, input logic [15:0] delay,
                                 input logic [15:0] interval, input logic [7:0] probes,
                                 input logic [7:0] limit);
      write_reg(REG_ENABLE, {15'd0, en});
      write_reg(REG_START_DELAY, delay);
      write_reg(REG_CHECK_INTERVAL, interval);
      write_reg(REG_PROBES, {8'd0, probes});
      write_reg(REG_FAILURE_LIMIT, {8'd0, limit});
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // report checking and receiver back-pressure
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_reports
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_reports.size() == 0) begin
               $error("report transfer with nothing awaited");
               error_count++;
            end else begin
               want = awaited_reports.pop_front();
               reports_checked++;
               if (rsp_send_probe !== want.send_probe) begin
                  $error("send_probe: expected %0d, actual %0d",
                         want.send_probe, rsp_send_probe);
                  error_count++;
               end
               if (rsp_probe_sequence !== want.probe_sequence) begin
                  $error("probe_sequence: expected %0d, actual %0d",
                         want.probe_sequence, rsp_probe_sequence);
                  error_count++;
               end
               if (rsp_check_done !== want.check_done) begin
                  $error("check_done: expected %0d, actual %0d",
                         want.check_done, rsp_check_done);
                  error_count++;
               end
               if (rsp_check_failed !== want.check_failed) begin
                  $error("check_failed: expected %0d, actual %0d",
                         want.check_failed, rsp_check_failed);
                  error_count++;
               end
               if (rsp_escalation !== want.escalation) begin
                  $error("escalation: expected %0d, actual %0d",
                         want.escalation, rsp_escalation);
                  error_count++;
               end
               if (rsp_reply_matched !== want.reply_matched) begin
                  $error("reply_matched: expected %0d, actual %0d",
                         want.reply_matched, rsp_reply_matched);
                  error_count++;
               end
               probes_seen  += rsp_send_probe;
               bursts_ended += rsp_check_done;
               if (rsp_escalation != 2'd0) escalations_seen++;
            end
         end
         rsp_stall <= !steady && ($urandom_range(99) < 19);
      end
   end

   // hang guard: any transfer on any channel restarts the count
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // default registers; reset timers put the block straight into a burst
   // whose slot count wraps round, then reply matching on each field, then a start and a start-delay tick
   task automatic test_power_on();
      send_op(OP_TICK, 1'b1, 16'h0000, 8'h00, 16'h0000);
      send_op(OP_REPLY, 1'b0, PROBE_IDENT, ECHO_REPLY_KIND, probe_seq);
      send_op(OP_REPLY, 1'b1, 16'hFFFF, ECHO_REPLY_KIND, probe_seq);
      send_op(OP_REPLY, 1'b0, PROBE_IDENT, 8'hFF, probe_seq);
      send_op(OP_REPLY, 1'b0, PROBE_IDENT, ECHO_REPLY_KIND, 16'hFFFF);
      send_op(OP_START, 1'b1, 16'hFFFF, 8'hFF, 16'hFFFF);
      send_op(OP_TICK, 1'b0, 16'h0000, 8'h00, 16'h0000);
   endtask

   // one-probe bursts with a limit of one: every unanswered burst climbs
   // one level, through port, switch and reboot, then past the top
   task automatic test_escalation_ladder();
      settle();
      apply_settings(1'b1, 16'd0, 16'd0, 8'd1, 8'd1);
      // zero start delay: first burst tick finds no slot left
      send_op(OP_START, 1'b0, 16'h0000, 8'h00, 16'h0000);
      send_op(OP_TICK, 1'b0, 16'h0000, 8'h00, 16'h0000);
      send_op(OP_RESTART, 1'b0, 16'h0000, 8'h00, 16'h0000);
      repeat (4) begin
         send_op(OP_TICK, 1'b1, 16'h0000, 8'h00, 16'h0000);
         // the escalation wait of two ticks
         send_op(OP_TICK, 1'b1, 16'h0000, 8'h00, 16'h0000);
         send_op(OP_TICK, 1'b0, 16'h0000, 8'h00, 16'h0000);
      end
   endtask

   // supervision off: ticks frozen, commands and replies still taken
   task automatic test_supervision_off();
      settle();
      apply_settings(1'b0, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
      send_op(OP_TICK, 1'b1, 16'h0000, 8'h00, 16'h0000);
      send_op(OP_RESTART, 1'b0, 16'h0000, 8'h00, 16'h0000);
      send_op(OP_TICK, 1'b1, 16'h0000, 8'h00, 16'h0000);
      send_op(OP_REPLY, 1'b0, PROBE_IDENT, ECHO_REPLY_KIND, probe_seq);
      send_op(OP_START, 1'b0, 16'h0000, 8'h00, 16'h0000);
   endtask

   // mostly ticks and well-formed replies to the live sequence, with
   // corrupt and stale replies, starts and restarts mixed in
   task automatic random_event();
      item_type    ev;
      int unsigned pick;
      pick              = $urandom_range(99);
      ev.transmit_ready = ($urandom_range(99) < 80);
      ev.reply_ident    = 16'($urandom);
      ev.reply_kind     = 8'($urandom);
      ev.reply_sequence = 16'($urandom);
      if (pick < 58) begin
         ev.operation = OP_TICK;
      end else if (pick < 86) begin
         ev.operation = OP_REPLY;
         if ($urandom_range(99) < 75) begin
            ev.reply_ident    = PROBE_IDENT;
            ev.reply_kind     = ECHO_REPLY_KIND;
            ev.reply_sequence = ($urandom_range(99) < 80)
                                ? probe_seq
                                : probe_seq - 16'($urandom_range(1, 2));
            // wrong message type on an otherwise good reply
            if ($urandom_range(99) < 10) ev.reply_kind = 8'($urandom_range(1, 255));
         end
      end else if (pick < 93) begin
         ev.operation = OP_RESTART;
      end else begin
         ev.operation = OP_START;
      end
      send_event(ev);
   endtask

   task automatic test_random_traffic();
      for (int ph = 0; ph < 6; ph++) begin
         settle();
         case (ph)
            1: apply_settings(1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
            2: apply_settings(1'b1, 16'd0, 16'd0, 8'd1, 8'd1);
            3: apply_settings(1'b0, 16'($urandom), 16'($urandom),
                              8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
            default: apply_settings(1'b1, 16'($urandom_range(0, 4)),
                                    16'($urandom_range(0, 4)),
                                    8'($urandom_range(1, 4)), 8'($urandom_range(1, 3)));
         endcase
         // one phase runs flat out on both channels
         steady = (ph == 4);
         repeat (88) random_event();
      end
      steady = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // sequencing
   // ------------------------------------------------------------------------
   initial begin
      // shadow starts from the reset values of the block
      watch_cfg.enable           = 1'b1;
      watch_cfg.start_delay      = 16'd60;
      watch_cfg.check_interval   = 16'd60;
      watch_cfg.probes_per_check = 8'd3;
      watch_cfg.failure_limit    = 8'd3;
      start_count    = '0;
      interval_count = '0;
      slots_left     = '0;
      probes_open    = '0;
      failed_checks  = '0;
      probe_seq      = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_power_on();
      test_escalation_ladder();
      test_supervision_off();
      test_random_traffic();

      // drain, then wait on to catch any stray report
      settle();
      repeat (8) @(posedge clock);

      $display("covered %0d events, %0d reports checked", events_sent, reports_checked);
      $display("seen %0d probes, %0d ended bursts, %0d escalations",
               probes_seen, bursts_ended, escalations_seen);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/llw_pkg.sv
rtl/llw_csr.sv
rtl/llw_engine.sv
rtl/link_liveness_watchdog.sv
bench/link_liveness_watchdog_tb.sv
